// File: rtl/core/sorted_id_list_difference_defines.svh
// ----------------------------------------------------------------------------
// Sorted id list difference: assertion macros
// Shared property forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef SORTED_ID_LIST_DIFFERENCE_DEFINES_SVH
`define SORTED_ID_LIST_DIFFERENCE_DEFINES_SVH

// same-cycle implication, masked during reset
`define SLD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sld implication check failed");

// next-cycle implication, masked during reset
`define SLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sld next-cycle check failed");

`endif

// File: rtl/core/sld_pkg.sv
// ----------------------------------------------------------------------------
// Sorted id list difference: package
// Sizes, codes, word types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sld_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int ID_BITS    = 16;
  localparam int GID_W      = 16;
  // stored id width: the input field is 16 bits wide
  localparam int STORE_W    = (ID_BITS < GID_W) ? ID_BITS : GID_W;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = $clog2(LIST_DEPTH);

  typedef enum logic [1:0] {
    OP_APPEND_CUR = 2'd0,
    OP_APPEND_OTH = 2'd1,
    OP_COMPARE    = 2'd2,
    OP_CLEAR      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_MORE = 2'd0,
    KIND_MISS = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [GID_W-1:0] grid_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [GID_W-1:0] grid_id_res;
    logic             overflow;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic  load_cur;
    logic  load_oth;
    logic  clear;
    logic  start;
    logic  adv_i;
    logic  adv_j;
    logic  emit;
    kind_t emit_kind;
  } sld_cmd_t;

  typedef struct packed {
    logic cur_left;
    logic oth_left;
    logic ids_equal;
    logic cur_less;
    logic slot_free;
  } sld_status_t;

endpackage

`default_nettype wire

// File: rtl/core/sld_datapath.sv
// ----------------------------------------------------------------------------
// Sorted id list difference: datapath
// Both id lists, counts, merge pointers, overflow flag and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_datapath
  import sld_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [GID_W-1:0] load_id,
  input  wire sld_cmd_t         cmd,
  output sld_status_t           status,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output out_word_t             out_data
);

  logic [STORE_W-1:0] cur_mem [LIST_DEPTH];
  logic [STORE_W-1:0] oth_mem [LIST_DEPTH];

  logic [CNT_W-1:0] cur_cnt_r, cur_cnt_nxt;
  logic [CNT_W-1:0] oth_cnt_r, oth_cnt_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r;

  logic             cur_full, oth_full;
  logic [STORE_W-1:0] cur_id_r, oth_id_r;
  logic [GID_W-1:0]   emit_id;

  assign cur_full = (cur_cnt_r == CNT_W'(LIST_DEPTH));
  assign oth_full = (oth_cnt_r == CNT_W'(LIST_DEPTH));

  assign status.cur_left  = (i_r < cur_cnt_r);
  assign status.oth_left  = (j_r < oth_cnt_r);
  assign status.ids_equal = (cur_id_r == oth_id_r);
  assign status.cur_less  = (cur_id_r < oth_id_r);
  assign status.slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_cur && !cur_full) begin
      cur_mem[cur_cnt_r[IDX_W-1:0]] <= load_id[STORE_W-1:0];
    end
    if (cmd.load_oth && !oth_full) begin
      oth_mem[oth_cnt_r[IDX_W-1:0]] <= load_id[STORE_W-1:0];
    end
    // read at the next pointer so the data lines up with i_r / j_r;
    // a pointer at full depth wraps but is never used past its count
    cur_id_r <= cur_mem[i_nxt[IDX_W-1:0]];
    oth_id_r <= oth_mem[j_nxt[IDX_W-1:0]];
  end

  always_comb begin
    cur_cnt_nxt = cur_cnt_r;
    oth_cnt_nxt = oth_cnt_r;
    ovf_nxt     = ovf_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    if (cmd.clear) begin
      cur_cnt_nxt = '0;
      oth_cnt_nxt = '0;
      ovf_nxt     = 1'b0;
    end
    if (cmd.load_cur) begin
      if (cur_full) ovf_nxt = 1'b1;
      else          cur_cnt_nxt = cur_cnt_r + CNT_W'(1);
    end
    if (cmd.load_oth) begin
      if (oth_full) ovf_nxt = 1'b1;
      else          oth_cnt_nxt = oth_cnt_r + CNT_W'(1);
    end
    if (cmd.start) begin
      i_nxt = '0;
      j_nxt = '0;
    end
    if (cmd.adv_i) i_nxt = i_r + CNT_W'(1);
    if (cmd.adv_j) j_nxt = j_r + CNT_W'(1);
  end

  always_comb begin
    case (cmd.emit_kind)
      KIND_MORE: emit_id = GID_W'(cur_id_r);
      KIND_MISS: emit_id = GID_W'(oth_id_r);
      default:   emit_id = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)         out_valid_nxt = 1'b1;
    else if (out_ready)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_cnt_r   <= '0;
      oth_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_cnt_r   <= cur_cnt_nxt;
      oth_cnt_r   <= oth_cnt_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word_r.kind        <= cmd.emit_kind;
      out_word_r.grid_id_res <= emit_id;
      out_word_r.overflow    <= (cmd.emit_kind == KIND_DONE) && ovf_r;
      out_word_r.last        <= (cmd.emit_kind == KIND_DONE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

`default_nettype wire

// File: rtl/core/sld_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted id list difference: controller
// Accepts words; sequences two-pointer merge, one step a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sld_ctrl
  import sld_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [1:0]  in_opcode,
  output logic             in_ready,
  input  wire sld_status_t status,
  output sld_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.emit_kind = KIND_DONE;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (opcode_t'(in_opcode))
            OP_APPEND_CUR: cmd.load_cur = 1'b1;
            OP_APPEND_OTH: cmd.load_oth = 1'b1;
            OP_CLEAR:      cmd.clear    = 1'b1;
            OP_COMPARE: begin
              cmd.start = 1'b1;
              state_nxt = ST_MERGE;
            end
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        if (status.slot_free) begin
          if (status.cur_left && status.oth_left) begin
            if (status.ids_equal) begin
              cmd.adv_i = 1'b1;
              cmd.adv_j = 1'b1;
            end else if (status.cur_less) begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = KIND_MORE;
              cmd.adv_i     = 1'b1;
            end else begin
              cmd.emit      = 1'b1;
              cmd.emit_kind = KIND_MISS;
              cmd.adv_j     = 1'b1;
            end
          end else if (status.cur_left) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_MORE;
            cmd.adv_i     = 1'b1;
          end else if (status.oth_left) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_MISS;
            cmd.adv_j     = 1'b1;
          end else begin
            // both lists exhausted: done marker closes the run
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_DONE;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sorted_id_list_difference.sv
// ----------------------------------------------------------------------------
// Sorted id list difference: top level
// Two ascending id lists; a compare word emits their difference by merge.
// ----------------------------------------------------------------------------
//   channel | ports                         | word
//   --------+-------------------------------+-----------------------
//   input   | in_valid, in_ready, in_data   | in_word_t  (opcode, id)
//   result  | out_valid, out_ready, out_data| out_word_t (kind, id, ovf, last)
//
// Append and clear words produce no result.
// A compare holds input off while the merge runs after its accept: the
// merge step walks one pointer (or both on a match) per cycle while the
// result slot is free, and the done marker takes the last step; input
// returns once it is registered. A stalled result register stalls the merge.
// Reset (synchronous, rst_n low) empties both lists and clears overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_id_list_difference
  import sld_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  sld_cmd_t    cmd;
  sld_status_t status;

  sld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sld_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_id   (in_data.grid_id),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: rtl/core/sld_checker.sv
// ----------------------------------------------------------------------------
// Sorted id list difference: port checker
// Watches the top-level ports; bound to every instance of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_id_list_difference_defines.svh"

module sld_checker
  import sld_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_word_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  logic done_word;
  assign done_word = (out_data.kind == KIND_DONE);

  `SLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `SLD_ASSERT_IMPLY(a_last_on_done, clk, rst_n, out_valid, out_data.last == done_word)
  `SLD_ASSERT_IMPLY(a_ovf_only_done, clk, rst_n, out_valid && !done_word, !out_data.overflow)
  `SLD_ASSERT_IMPLY(a_done_zero_id, clk, rst_n, out_valid && done_word, out_data.grid_id_res == '0)
  `SLD_ASSERT_NEXT(a_cmp_busy, clk, rst_n, in_valid && in_ready && (in_data.opcode == OP_COMPARE), !in_ready)

endmodule

bind sorted_id_list_difference sld_checker u_sld_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/sv/sorted_id_list_difference_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted id list difference: testbench
// Drives append, clear and compare words through the valid/ready input
// channel, predicts the merge difference of the two stored id lists and
// checks every result word in order under varying sender and receiver stalls.
// ----------------------------------------------------------------------------

module sorted_id_list_difference_test;
  import sld_pkg::*;

  localparam int RANDOM_WORDS = 220;
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  localparam int CYCLE_LIMIT  = 200000;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors both lists and queues the expected difference words
  // --------------------------------------------------------------------------
  class id_diff_scoreboard;
    logic [STORE_W-1:0] cur_ids [LIST_DEPTH];
    logic [STORE_W-1:0] oth_ids [LIST_DEPTH];
    int unsigned        cur_n;
    int unsigned        oth_n;
    logic               ovf_sticky;
    out_word_t          expected_diffs[$];
    int unsigned        errors;
    int unsigned        compares;
    int unsigned        results_checked;

    function new();
      cur_n           = 0;
      oth_n           = 0;
      ovf_sticky      = 1'b0;
      errors          = 0;
      compares        = 0;
      results_checked = 0;
    endfunction

    function void push_diff(kind_t kind, logic [GID_W-1:0] id, logic ovf, logic fin);
      out_word_t r;
      r.kind        = kind;
      r.grid_id_res = id;
      r.overflow    = ovf;
      r.last        = fin;
      expected_diffs = {expected_diffs, r};
    endfunction

    // two-pointer walk over the stored order, sorted or not
    function void predict_difference();
      int unsigned i;
      int unsigned j;
      i = 0;
      j = 0;
      while (i < cur_n && j < oth_n) begin
        if (cur_ids[i] == oth_ids[j]) begin
          i++;
          j++;
        end else if (cur_ids[i] > oth_ids[j]) begin
          push_diff(KIND_MISS, GID_W'(oth_ids[j]), 1'b0, 1'b0);
          j++;
        end else begin
          push_diff(KIND_MORE, GID_W'(cur_ids[i]), 1'b0, 1'b0);
          i++;
        end
      end
      for (; i < cur_n; i++) push_diff(KIND_MORE, GID_W'(cur_ids[i]), 1'b0, 1'b0);
      for (; j < oth_n; j++) push_diff(KIND_MISS, GID_W'(oth_ids[j]), 1'b0, 1'b0);
      push_diff(KIND_DONE, '0, ovf_sticky, 1'b1);
      compares++;
    endfunction

    function void note_word(in_word_t w);
      case (opcode_t'(w.opcode))
        OP_APPEND_CUR: begin
          if (cur_n >= LIST_DEPTH) ovf_sticky = 1'b1;
          else begin
            cur_ids[cur_n] = w.grid_id[STORE_W-1:0];
            cur_n++;
          end
        end
        OP_APPEND_OTH: begin
          if (oth_n >= LIST_DEPTH) ovf_sticky = 1'b1;
          else begin
            oth_ids[oth_n] = w.grid_id[STORE_W-1:0];
            oth_n++;
          end
        end
        OP_CLEAR: begin
          cur_n      = 0;
          oth_n      = 0;
          ovf_sticky = 1'b0;
        end
        default: predict_difference();
      endcase
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_word(out_word_t got);
      out_word_t want;
      if (expected_diffs.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: kind %0d id %h",
                                  got.kind, got.grid_id_res));
        return;
      end
      want = expected_diffs.pop_front();
      results_checked++;
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.grid_id_res !== want.grid_id_res)
        report_mismatch($sformatf("grid_id_res %h, want %h", got.grid_id_res,
                                  want.grid_id_res));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("overflow %b, want %b", got.overflow, want.overflow));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
    endtask

    task check_leftovers();
      if (expected_diffs.size() != 0)
        report_mismatch($sformatf("%0d result words never arrived", expected_diffs.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT, counters
  // --------------------------------------------------------------------------
  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  id_diff_scoreboard sb;
  int unsigned       cycle_count = 0;
  int unsigned       sent_words  = 0;
  int                in_idle_pct  = 0;
  int                out_stall_pct = 0;

  always #10 clk = ~clk;

  sorted_id_list_difference DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random back-pressure, results sampled mid-cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic [GID_W-1:0] random_id();
    return GID_W'($urandom_range(0, 2 ** GID_W - 1));
  endfunction

  function automatic int pick_list_size();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 5);
    else if (r < 8) return $urandom_range(6, 12);
    else if (r == 8) return LIST_DEPTH;
    else return $urandom_range(LIST_DEPTH + 1, LIST_DEPTH + 3);
  endfunction

  // valid stays up between back-to-back words; lowered only for an idle gap
  task automatic send_word(opcode_t op, logic [GID_W-1:0] id);
    in_word_t w;
    w.opcode  = op;
    w.grid_id = id;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(negedge clk); while (!in_ready);
    sb.note_word(w);
    sent_words++;
    @(posedge clk);
  endtask

  // clear (mostly), load two ascending lists with shared ids, then compare
  task automatic send_list_pair();
    logic [GID_W-1:0] cur_q[$];
    logic [GID_W-1:0] oth_q[$];
    int               want_cur;
    int               want_oth;
    int               step_max;
    int               pick;
    int unsigned      v;
    want_cur = pick_list_size();
    want_oth = pick_list_size();
    if (want_cur > 8 || want_oth > 8) step_max = 64;
    else if ($urandom_range(0, 2) == 0) step_max = 3;
    else step_max = $urandom_range(0, 1) ? 300 : 6000;
    v = $urandom_range(0, 1) ? $urandom_range(0, 63) : $urandom_range(0, 65535);
    while ((cur_q.size() < want_cur || oth_q.size() < want_oth) && v <= 65535) begin
      pick = $urandom_range(0, 3);  // 2 and 3: id in both lists
      if (cur_q.size() >= want_cur) pick = 1;
      else if (oth_q.size() >= want_oth) pick = 0;
      if (pick != 1) cur_q = {cur_q, v[GID_W-1:0]};
      if (pick != 0) oth_q = {oth_q, v[GID_W-1:0]};
      v += $urandom_range(1, step_max);
    end
    // now and then keep the old lists and pile on top of them
    if ($urandom_range(0, 7) != 0) send_word(OP_CLEAR, random_id());
    while (cur_q.size() != 0 || oth_q.size() != 0) begin
      if (oth_q.size() == 0 || (cur_q.size() != 0 && $urandom_range(0, 1)))
        send_word(OP_APPEND_CUR, cur_q.pop_front());
      else
        send_word(OP_APPEND_OTH, oth_q.pop_front());
    end
    send_word(OP_COMPARE, random_id());
    if ($urandom_range(0, 3) == 0) send_word(OP_COMPARE, random_id());
  endtask

  task automatic set_idling(int phase_idx);
    case (phase_idx)
      0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1:       begin in_idle_pct = 45; out_stall_pct = 0;  end
      2:       begin in_idle_pct = 0;  out_stall_pct = 45; end
      default: begin in_idle_pct = 29; out_stall_pct = 29; end
    endcase
  endtask

  initial begin
    int unsigned random_base;
    int unsigned k;
    sb        = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty lists, extremes, equal ids
    send_word(OP_COMPARE, 16'hFFFF);
    send_word(OP_APPEND_CUR, 16'h0000);
    send_word(OP_APPEND_CUR, 16'hFFFF);
    send_word(OP_APPEND_OTH, 16'h0000);
    send_word(OP_APPEND_OTH, 16'h0001);
    send_word(OP_APPEND_OTH, 16'hFFFF);
    send_word(OP_COMPARE, 16'h0000);
    send_word(OP_CLEAR, 16'h0000);
    // unsorted appends past capacity; other list empty
    for (k = 0; k <= LIST_DEPTH; k++)
      send_word(OP_APPEND_CUR, k[0] ? GID_W'(k * 5) : GID_W'(16'hFFFF - k * 3));
    send_word(OP_COMPARE, 16'h5A5A);
    send_word(OP_CLEAR, 16'hFFFF);

    random_base = sent_words;
    while (sent_words - random_base < RANDOM_WORDS) begin
      set_idling((sent_words - random_base) * 4 / RANDOM_WORDS);
      if ($urandom_range(0, 7) == 0) send_word(opcode_t'($urandom_range(0, 3)), random_id());
      else send_list_pair();
    end
    in_valid <= 1'b0;

    while (sb.expected_diffs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.check_leftovers();

    $display("Sent %0d words over four stall mixes; %0d compare runs predicted.",
             sent_words, sb.compares);
    $display("Checked %0d result words, %0d mismatches.", sb.results_checked, sb.errors);
    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
